[sv/pcef_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the PNG chunk end finder.
// No dependencies; imported by every module of the block.
package pcef_pkg;

    localparam int unsigned SIG_BYTES      = 8;
    localparam int unsigned LEN_BYTES      = 4;
    localparam int unsigned CRC_BYTES      = 4;
    localparam logic [31:0] END_TYPE_RESET = 32'h4945_4E44;  // "IEND"

    // Register index decoded from paddr
    localparam logic REG_END_TYPE = 1'b0;

    typedef enum logic [1:0] {
        ST_END_FOUND  = 2'd0,
        ST_NO_END     = 2'd1,
        ST_NEG_LENGTH = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
        logic       end_of_data;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] image_length;
        logic [31:0] bad_chunk_length;
    } t_result;

endpackage

[sv/pcef_apb_regs.sv]
`timescale 1ns / 1ps
// APB register file: holds the end chunk type.
// Depends on pcef_pkg.
module pcef_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_end_type
);
    import pcef_pkg::*;

    logic [31:0] r_end_type;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_type <= END_TYPE_RESET;
        end else if (wr_en && (paddr[2] == REG_END_TYPE)) begin
            r_end_type <= pwdata;
        end
    end

    assign prdata     = (paddr[2] == REG_END_TYPE) ? r_end_type : 32'd0;
    assign o_end_type = r_end_type;

endmodule

[sv/pcef_in_stage.sv]
`timescale 1ns / 1ps
// Input register: holds one accepted request until the walker takes it.
// Depends on pcef_pkg.
module pcef_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pcef_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_take,
    output logic            o_valid,
    output pcef_pkg::t_item o_item
);
    import pcef_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[sv/pcef_walker.sv]
`timescale 1ns / 1ps
// Chunk walker: per-byte state update and the result register.
// Depends on pcef_pkg.
module pcef_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_end_type,
    input  logic              i_valid,
    input  pcef_pkg::t_item   i_item,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output pcef_pkg::t_result o_result
);
    import pcef_pkg::*;

    typedef enum logic [1:0] {
        PH_SIG  = 2'd0,
        PH_HDR  = 2'd1,
        PH_SKIP = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [31:0] r_pos,      n_pos;
    logic [2:0]  r_hidx,     n_hidx;
    logic [31:0] r_len,      n_len;
    logic [31:0] r_type,     n_type;
    logic [32:0] r_skip,     n_skip;
    logic        r_out_valid, n_out_valid;
    t_result     r_result,   n_result;

    t_phase      c_phase;
    logic [31:0] c_pos, c_len, c_type;
    logic [2:0]  c_hidx;
    logic [32:0] c_skip;
    logic        pos_sat;
    logic [33:0] next_end;
    logic        emitted;

    assign o_take  = i_valid && (!r_out_valid || i_ready);
    assign pos_sat = (c_pos == 32'hFFFF_FFFF);
    // Position after this byte plus length plus CRC
    assign next_end = {2'b00, c_pos} + {2'b00, c_len}
                    + (pos_sat ? 34'(CRC_BYTES) : 34'(CRC_BYTES + 1));

    always_comb begin
        // Start flag restarts the walk before this byte counts
        if (i_item.start_of_image) begin
            c_phase = PH_SIG;
            c_pos   = 32'd0;
            c_hidx  = 3'd0;
            c_len   = 32'd0;
            c_type  = 32'd0;
            c_skip  = 33'd0;
        end else begin
            c_phase = r_phase;
            c_pos   = r_pos;
            c_hidx  = r_hidx;
            c_len   = r_len;
            c_type  = r_type;
            c_skip  = r_skip;
        end

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_hidx   = r_hidx;
        n_len    = r_len;
        n_type   = r_type;
        n_skip   = r_skip;
        emitted  = 1'b0;
        n_result = r_result;
        n_out_valid = r_out_valid && !i_ready;

        if (o_take) begin
            n_phase = c_phase;
            n_pos   = c_pos;
            n_hidx  = c_hidx;
            n_len   = c_len;
            n_type  = c_type;
            n_skip  = c_skip;
            if (c_phase != PH_DONE) begin
                n_pos = pos_sat ? c_pos : c_pos + 32'd1;
                case (c_phase)
                    PH_SIG: begin
                        if (n_pos >= 32'(SIG_BYTES)) begin
                            n_phase = PH_HDR;
                            n_hidx  = 3'd0;
                        end
                    end
                    PH_HDR: begin
                        if (c_hidx < 3'(LEN_BYTES)) begin
                            n_len = {c_len[23:0], i_item.data_byte};
                        end else begin
                            n_type = {c_type[23:0], i_item.data_byte};
                        end
                        n_hidx = c_hidx + 3'd1;
                        if (c_hidx == 3'd7) begin
                            // Header complete; length already collected
                            if (c_len[31]) begin
                                emitted  = 1'b1;
                                n_result = '{ST_NEG_LENGTH, 32'd0, c_len};
                            end else if (next_end[33:32] != 2'b00) begin
                                emitted  = 1'b1;
                                n_result = '{ST_OVERFLOW, 32'd0, 32'd0};
                            end else if (n_type == i_end_type) begin
                                emitted  = 1'b1;
                                n_result = '{ST_END_FOUND, next_end[31:0], 32'd0};
                            end else begin
                                n_skip  = {1'b0, c_len} + 33'(CRC_BYTES);
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (c_skip != 33'd0) begin
                            n_skip = c_skip - 33'd1;
                        end
                        if (n_skip == 33'd0) begin
                            n_phase = PH_HDR;
                            n_hidx  = 3'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
                if (!emitted && i_item.end_of_data) begin
                    emitted  = 1'b1;
                    n_result = '{ST_NO_END, 32'd0, 32'd0};
                end
                if (emitted) begin
                    n_phase     = PH_DONE;
                    n_out_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_pos       <= 32'd0;
            r_hidx      <= 3'd0;
            r_len       <= 32'd0;
            r_type      <= 32'd0;
            r_skip      <= 33'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_hidx      <= n_hidx;
            r_len       <= n_len;
            r_type      <= n_type;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

[sv/png_chunk_end_finder_core.sv]
`timescale 1ns / 1ps
// PNG chunk end finder, top level: APB registers, input register, walker.
// Depends on pcef_pkg, pcef_apb_regs, pcef_in_stage, pcef_walker.
//
// Feed the image one byte per request on the slave stream; set tuser on the
// first signature byte to restart the walk (reset acts as a restart too) and
// tlast on the last byte available. The block skips the 8 signature bytes,
// collects each 8-byte chunk header and skips length plus 4 CRC bytes. When a
// header carries the type held in the end_chunk_type register (address 0,
// reset "IEND") it emits one result with status 0 and the image length from
// the first signature byte through that chunk's CRC, without waiting for the
// chunk body. Status 1 means the data ended first, 2 a length word with bit
// 31 set (raw word in bad_chunk_length), 3 a chunk end past 2^32-1 bytes.
// After a result, bytes are dropped until the next start flag. A request
// enters the input register; the walker takes it from there, updates its
// counters and writes the result register, so one byte per clock is
// sustained while the master side keeps tready high. The result register
// drives the result port. Write the register only while the block is idle.
module png_chunk_end_finder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_image
    input  logic        s_axis_tlast,   // end_of_data
    // Result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] image_length, [63:32] bad_chunk_length
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pcef_pkg::*;

    logic        end_type;
    logic [31:0] end_type_word;
    t_item       in_item;
    t_item       stage_item;
    logic        stage_valid;
    logic        stage_take;
    t_result     result;

    assign end_type = 1'b0;

    pcef_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_end_type (end_type_word)
    );

    // Pack the request fields
    assign in_item.data_byte      = s_axis_tdata;
    assign in_item.start_of_image = s_axis_tuser[0] | end_type;
    assign in_item.end_of_data    = s_axis_tlast;

    pcef_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (in_item),
        .o_ready (s_axis_tready),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    pcef_walker u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_end_type (end_type_word),
        .i_valid    (stage_valid),
        .i_item     (stage_item),
        .o_take     (stage_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {result.bad_chunk_length, result.image_length};
    assign m_axis_tuser = result.status;

endmodule

[tb/tb_png_chunk_end_finder_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for png_chunk_end_finder_core: byte streams of PNG-like images,
// a built-in chunk-walk predictor and a result scoreboard. Depends on pcef_pkg and the RTL.
module tb_png_chunk_end_finder_core;
    import pcef_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500_000;
    // Margin for the input register and the walker to drain after the last result.
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {
        WALK_SIG,
        WALK_HDR,
        WALK_SKIP,
        WALK_DONE
    } t_walk_phase;

    typedef enum logic [1:0] {
        RX_STREAM,   // always ready
        RX_COIN,     // ready on a coin toss
        RX_SPARSE,   // ready one cycle in four
        RX_HICCUP    // mostly ready, rare single stalls
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] start_of_image
    logic        s_axis_tlast;   // end_of_data
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] image_length, [63:32] bad_chunk_length
    logic [1:0]  m_axis_tuser;   // [1:0] status

    png_chunk_end_finder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Walk predictor state: a private copy of the block's chunk walker
    // and of its end-type register.
    // ------------------------------------------------------------------
    t_walk_phase walk_phase;
    logic [31:0] walk_pos;        // bytes since start, saturating
    logic [2:0]  hdr_idx;         // next header byte
    logic [31:0] len_word;
    logic [31:0] type_word;
    logic [32:0] skip_left;       // body plus CRC bytes still to skip
    logic [31:0] end_type;

    t_result     pending_verdicts[$];   // expected results, oldest first
    t_item       image_bytes[$];        // bytes of the image being built
    int unsigned walked_bytes;          // requests the walker did not drop
    int unsigned burst_left;
    int unsigned error_count;
    int unsigned cycle_count;

    function automatic void restart_walk();
        walk_phase = WALK_SIG;
        walk_pos   = '0;
        hdr_idx    = '0;
        len_word   = '0;
        type_word  = '0;
        skip_left  = '0;
    endfunction

    // Advance the walk by one accepted byte; queue the verdict it causes.
    // Returns 0 when the byte is dropped because the walk is done.
    function automatic bit track_image_byte(t_item it);
        t_result     verdict;
        bit          settled;
        logic [32:0] chunk_end;
        verdict = '0;
        settled = 1'b0;
        if (it.start_of_image)
            restart_walk();
        if (walk_phase == WALK_DONE)
            return 1'b0;
        if (walk_pos != 32'hFFFF_FFFF)
            walk_pos = walk_pos + 1;
        case (walk_phase)
            WALK_SIG: begin
                if (walk_pos >= SIG_BYTES) begin
                    walk_phase = WALK_HDR;
                    hdr_idx    = '0;
                end
            end
            WALK_HDR: begin
                if (hdr_idx < LEN_BYTES)
                    len_word = {len_word[23:0], it.data_byte};
                else
                    type_word = {type_word[23:0], it.data_byte};
                hdr_idx = hdr_idx + 1;
                if (hdr_idx == 0) begin
                    chunk_end = {1'b0, walk_pos} + len_word + CRC_BYTES;
                    if (len_word[31]) begin
                        verdict.status           = ST_NEG_LENGTH;
                        verdict.bad_chunk_length = len_word;
                        settled                  = 1'b1;
                    end else if (chunk_end[32]) begin
                        verdict.status = ST_OVERFLOW;
                        settled        = 1'b1;
                    end else if (type_word == end_type) begin
                        verdict.status       = ST_END_FOUND;
                        verdict.image_length = chunk_end[31:0];
                        settled              = 1'b1;
                    end else begin
                        skip_left  = len_word + CRC_BYTES;
                        walk_phase = WALK_SKIP;
                    end
                end
            end
            default: begin
                if (skip_left != 0)
                    skip_left = skip_left - 1;
                if (skip_left == 0) begin
                    walk_phase = WALK_HDR;
                    hdr_idx    = '0;
                end
            end
        endcase
        // A verdict from the header wins over end of data on the same byte.
        if (!settled && it.end_of_data) begin
            verdict.status = ST_NO_END;
            settled        = 1'b1;
        end
        if (settled) begin
            pending_verdicts = {pending_verdicts, verdict};
            walk_phase = WALK_DONE;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Kill a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall on a random ready pattern that holds for a random number of cycles
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode;
    int unsigned rx_left;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (rx_left % 4 == 0);
            default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Compare each accepted result with the oldest expectation, field by field.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d length %0d bad %0d",
                         $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[31:0] !== want.image_length) begin
                    $display("%0t: image_length expected %0d actual %0d",
                             $time, want.image_length, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.bad_chunk_length) begin
                    $display("%0t: bad_chunk_length expected %h actual %h",
                             $time, want.bad_chunk_length, m_axis_tdata[63:32]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Offer one byte, hold it until accepted, then maybe idle between bursts.
    // Call at a rising edge; returns at a rising edge.
    task automatic send_byte(t_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data_byte;
        s_axis_tuser  <= it.start_of_image;
        s_axis_tlast  <= it.end_of_data;
        do @(posedge i_clk); while (!s_axis_tready);
        if (track_image_byte(it))
            walked_bytes++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_image();
        foreach (image_bytes[i])
            send_byte(image_bytes[i]);
        image_bytes.delete();
    endtask

    function automatic void add_byte(logic [7:0] b, logic sof, logic eod);
        image_bytes = {image_bytes,
                       t_item'{data_byte: b, start_of_image: sof, end_of_data: eod}};
    endfunction

    // Append a 32-bit word, first byte most significant, as in a chunk header.
    function automatic void add_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_byte(w[8*i +: 8], 1'b0, 1'b0);
    endfunction

    function automatic void add_random_bytes(int unsigned count);
        repeat (count) add_byte(8'($urandom), 1'b0, 1'b0);
    endfunction

    // Hold the stream until every expected result has come, then let the
    // pipeline drain so that a dropped byte cannot still be in flight.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_end_type(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_END_TYPE, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        end_type = value;
    endtask

    // Build one random image. Most are well formed with random content so
    // the walk goes deep; the rest are cut short, carry a negative or huge
    // length, restart in the middle, or are plain noise.
    function automatic void build_random_image();
        int unsigned kind;
        int unsigned cut;
        logic [31:0] len;
        logic [31:0] kind_type;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            // Noise: random bytes with stray start and end flags.
            repeat ($urandom_range(1, 30))
                add_byte(8'($urandom), ($urandom_range(0, 15) == 0),
                         ($urandom_range(0, 15) == 0));
            return;
        end
        add_byte(8'($urandom), ($urandom_range(0, 9) != 0), 1'b0);
        add_random_bytes(SIG_BYTES - 1);
        repeat ($urandom_range(0, 3)) begin
            len       = $urandom_range(0, 12);
            kind_type = $urandom;
            if (kind_type == end_type)
                kind_type[0] = ~kind_type[0];
            add_word(len);
            add_word(kind_type);
            add_random_bytes(len + CRC_BYTES);
        end
        if (kind < 65) begin
            // End chunk, sometimes with a length that uses every bit below 31.
            len = ($urandom_range(0, 2) == 0) ? {1'b0, 31'($urandom)} : $urandom_range(0, 12);
            add_word(len);
            add_word(end_type);
            if ($urandom_range(0, 3) == 0)
                image_bytes[image_bytes.size() - 1].end_of_data = 1'b1;
            // Trailing bytes go to a finished walk and are dropped.
            repeat ($urandom_range(0, 3))
                add_byte(8'($urandom), 1'b0, ($urandom_range(0, 1) == 1));
        end else if (kind < 72) begin
            add_word($urandom | 32'h8000_0000);
            add_word(($urandom_range(0, 1) == 1) ? end_type : $urandom);
        end else if (kind < 84) begin
            // Data ends anywhere before the end header completes.
            add_word($urandom_range(0, 12));
            add_word(end_type);
            cut = $urandom_range(0, image_bytes.size() - 2);
            image_bytes = image_bytes[0:cut];
            image_bytes[cut].end_of_data = 1'b1;
        end else begin
            // Huge chunk that the data never gets past.
            kind_type = $urandom;
            if (kind_type == end_type)
                kind_type[31] = ~kind_type[31];
            add_word({1'b0, 31'($urandom)});
            add_word(kind_type);
            add_random_bytes($urandom_range(0, 20));
            add_byte(8'($urandom), 1'b0, 1'b1);
        end
        // Now and then restart the walk partway through the image.
        if ($urandom_range(0, 19) == 0)
            image_bytes[$urandom_range(1, image_bytes.size() - 1)].start_of_image = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the walk runs without a start flag. A length word of all
    // ones on the reset end type is a negative length; later bytes, the end
    // flag among them, are dropped; a fresh start cut short in the
    // signature reports a missing end chunk.
    task automatic test_reset_walk();
        repeat (SIG_BYTES) add_byte(8'hFF, 1'b0, 1'b0);
        add_word(32'hFFFF_FFFF);
        add_word(END_TYPE_RESET);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'h00, 1'b1, 1'b0);
        add_random_bytes(1);
        add_byte(8'h00, 1'b0, 1'b1);
        send_image();
    endtask

    // Skip an empty chunk (CRC only), then complete the end header on the
    // very byte that carries the end flag: the end must still be reported.
    task automatic test_end_on_last_byte();
        add_byte(8'h00, 1'b1, 1'b0);
        add_random_bytes(SIG_BYTES - 1);
        add_word(32'h0000_0000);
        add_word(32'hFFFF_FFFF);
        repeat (CRC_BYTES) add_byte(8'hFF, 1'b0, 1'b0);
        add_word(32'h0000_0001);
        add_word(end_type);
        image_bytes[image_bytes.size() - 1].end_of_data = 1'b1;
        send_image();
    endtask

    task automatic test_random_walk(int unsigned walked_target);
        int unsigned walked_at_start;
        walked_at_start = walked_bytes;
        while (walked_bytes - walked_at_start < walked_target) begin
            build_random_image();
            send_image();
        end
    endtask

    // Rewrite the end type between phases: both extremes and a random value.
    task automatic test_end_type_settings();
        wait_for_idle();
        write_end_type(32'h0000_0000);
        test_random_walk(250);
        wait_for_idle();
        write_end_type(32'hFFFF_FFFF);
        test_random_walk(250);
        wait_for_idle();
        write_end_type($urandom);
        test_random_walk(350);
    endtask

    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cycle_count   = 0;
        error_count   = 0;
        walked_bytes  = 0;
        burst_left    = 0;
        rx_left       = 0;
        end_type      = END_TYPE_RESET;
        restart_walk();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_walk();
        test_end_on_last_byte();
        test_random_walk(500);
        test_end_type_settings();

        wait_for_idle();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
